>>> hdl/ffea_pkg.sv
// Package with the types, codes and helper function of the first-fit extent allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffea_pkg;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  localparam int SECTOR_W = 24;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  entry_index;
    logic [31:0] size_bytes;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic [31:0] first_sector;
    logic [31:0] entry_size;
  } rsp_t;

  typedef struct packed {
    logic        live;
    logic        hit;
    logic [32:0] cand;
  } scan_tok_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] start;
    logic [31:0] bytes;
  } extent_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_SCAN,
    ST_DONE
  } state_t;

  function automatic logic [SECTOR_W-1:0] sectors_of(input logic [31:0] bytes);
    sectors_of = {1'b0, bytes[31:9]} + {{(SECTOR_W-1){1'b0}}, |bytes[8:0]};
  endfunction

endpackage
`default_nettype wire

>>> hdl/ffea_cell.sv
// One table cell: holds an extent and tests the passing candidate against it.
`timescale 1ns / 1ps
`default_nettype none
module ffea_cell (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           sel,
  input  wire ffea_pkg::extent_t              wr,
  input  wire logic [ffea_pkg::SECTOR_W-1:0]  needed,
  input  wire ffea_pkg::scan_tok_t            tok_in,
  output ffea_pkg::scan_tok_t                 tok_out,
  output ffea_pkg::extent_t                   view
);

  logic        valid;
  logic [31:0] start;
  logic [31:0] bytes;
  logic [32:0] stop;
  logic        overlap;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sel) begin
      valid <= wr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      start <= wr.start;
      bytes <= wr.bytes;
      stop  <= {1'b0, wr.start} + {9'd0, ffea_pkg::sectors_of(wr.bytes)};
    end
  end

  assign overlap = valid && (tok_in.cand < stop) &&
                   (({1'b0, tok_in.cand} + {10'd0, needed}) > {2'b00, start});

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out.live <= tok_in.live;
      if (tok_in.live && overlap) begin
        tok_out.hit  <= 1'b1;
        tok_out.cand <= stop;
      end else begin
        tok_out.hit  <= tok_in.hit;
        tok_out.cand <= tok_in.cand;
      end
    end
  end

  always_comb begin
    view.valid = valid;
    view.start = start;
    view.bytes = bytes;
  end

endmodule
`default_nettype wire

>>> hdl/first_fit_extent_allocator_top.sv
// Top level of the first-fit extent allocator: controller and chain of table cells.
//
// An item is accepted at a rising edge with start high and busy low. It carries
// a mode (write/resize, free, read), an entry index and, for writes, a byte size.
// Exactly one result follows per item: done is high for one cycle while rsp holds
// the status, first sector and byte size of the entry after the operation. The
// receiver cannot stall; the result must be taken in that cycle.
// Reads, frees, out-of-range indexes and writes that keep their place pass from
// acceptance through the lookup and decide states to the done state; the next item
// can be accepted once the controller is back in idle. A write that must be placed
// and is no larger than the data area sends a candidate start down the chain of
// ENTRIES cells, one cell per cycle; every pass in which some extent overlaps moves
// the candidate past that extent and starts another pass. A placement takes between
// 1 and ENTRIES + 1 passes. busy stays high until the done cycle ends.
// The data area size is written through cfg_valid/cfg_ready/cfg_data; cfg_ready
// is always high and writes are expected only while busy is low.
// Reset clears the valid marks of all entries and the data area size.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_extent_allocator_top #(
  parameter int ENTRIES = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire ffea_pkg::cmd_t cmd,
  output logic                done,
  output ffea_pkg::rsp_t      rsp,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [31:0]    cfg_data
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  ffea_pkg::state_t    state, state_next;
  ffea_pkg::cmd_t      req;
  ffea_pkg::extent_t   cur;
  ffea_pkg::rsp_t      rsp_next;
  logic [31:0]         area;
  logic [ffea_pkg::SECTOR_W-1:0] needed;

  ffea_pkg::scan_tok_t tok [0:ENTRIES];
  ffea_pkg::scan_tok_t tok_head;
  ffea_pkg::extent_t   views [0:ENTRIES-1];
  ffea_pkg::extent_t   wr;
  logic                wr_en;

  logic [8:0]          idx_wide;
  logic [AW-1:0]       addr;
  logic                idx_ok;
  logic [ffea_pkg::SECTOR_W-1:0] cur_sectors;
  logic                need_place;
  logic                too_big;
  logic                fits;
  ffea_pkg::rsp_t      cur_rsp;

  assign idx_wide = {3'b000, req.entry_index};
  assign addr     = idx_wide[AW-1:0];
  assign idx_ok   = idx_wide < 9'(ENTRIES);

  assign tok[0] = tok_head;

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      ffea_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .sel     (wr_en && (addr == AW'(gi))),
        .wr      (wr),
        .needed  (needed),
        .tok_in  (tok[gi]),
        .tok_out (tok[gi+1]),
        .view    (views[gi])
      );
    end
  endgenerate

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      area <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      area <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffea_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ffea_pkg::ST_IDLE && start) begin
      req    <= cmd;
      needed <= ffea_pkg::sectors_of(cmd.size_bytes);
    end
    if (state == ffea_pkg::ST_LOOKUP) begin
      cur.valid <= views[addr].valid;
      cur.start <= views[addr].valid ? views[addr].start : 32'd0;
      cur.bytes <= views[addr].valid ? views[addr].bytes : 32'd0;
    end
    rsp <= rsp_next;
  end

  assign cur_sectors = ffea_pkg::sectors_of(cur.bytes);
  assign need_place  = (needed > cur_sectors) || (cur.start == 32'd0);
  assign too_big     = {8'd0, needed} > area;
  assign fits        = ({1'b0, tok[ENTRIES].cand} + {10'd0, needed}) <= {2'b00, area};

  always_comb begin
    cur_rsp.status       = ffea_pkg::STATUS_OK;
    cur_rsp.first_sector = cur.start;
    cur_rsp.entry_size   = cur.bytes;
  end

  always_comb begin
    state_next = state;
    rsp_next   = rsp;
    wr_en      = 1'b0;
    wr.valid   = 1'b1;
    wr.start   = 32'd0;
    wr.bytes   = req.size_bytes;
    tok_head.live = 1'b0;
    tok_head.hit  = 1'b0;
    tok_head.cand = 33'd0;
    busy = (state != ffea_pkg::ST_IDLE);
    done = (state == ffea_pkg::ST_DONE);
    case (state)
      ffea_pkg::ST_IDLE: begin
        if (start) begin
          state_next = ffea_pkg::ST_LOOKUP;
        end
      end
      ffea_pkg::ST_LOOKUP: begin
        state_next = ffea_pkg::ST_DECIDE;
      end
      ffea_pkg::ST_DECIDE: begin
        state_next = ffea_pkg::ST_DONE;
        rsp_next   = '0;
        if (idx_ok) begin
          case (req.mode)
            ffea_pkg::MODE_WRITE: begin
              if (!need_place) begin
                wr_en                 = 1'b1;
                wr.start              = cur.start;
                rsp_next.first_sector = cur.start;
                rsp_next.entry_size   = req.size_bytes;
              end else if (too_big) begin
                rsp_next        = cur_rsp;
                rsp_next.status = ffea_pkg::STATUS_NO_SPACE;
              end else begin
                tok_head.live = 1'b1;
                state_next    = ffea_pkg::ST_SCAN;
              end
            end
            ffea_pkg::MODE_FREE: begin
              wr_en    = 1'b1;
              wr.valid = 1'b0;
              wr.bytes = 32'd0;
            end
            default: begin
              rsp_next = cur_rsp;
            end
          endcase
        end
      end
      ffea_pkg::ST_SCAN: begin
        if (tok[ENTRIES].live) begin
          if (!fits) begin
            rsp_next        = cur_rsp;
            rsp_next.status = ffea_pkg::STATUS_NO_SPACE;
            state_next      = ffea_pkg::ST_DONE;
          end else if (tok[ENTRIES].hit) begin
            tok_head.live = 1'b1;
            tok_head.cand = tok[ENTRIES].cand;
          end else begin
            wr_en                 = 1'b1;
            wr.start              = tok[ENTRIES].cand[31:0];
            rsp_next.status       = ffea_pkg::STATUS_OK;
            rsp_next.first_sector = tok[ENTRIES].cand[31:0];
            rsp_next.entry_size   = req.size_bytes;
            state_next            = ffea_pkg::ST_DONE;
          end
        end
      end
      ffea_pkg::ST_DONE: begin
        state_next = ffea_pkg::ST_IDLE;
      end
      default: begin
        state_next = ffea_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> bench/tb.sv
// Self-checking testbench for the first-fit extent allocator top level.
`timescale 1ns / 1ps
module tb;

  localparam int ENTRIES = 64;
  localparam logic [1:0] MODE_ALT_READ = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  ffea_pkg::cmd_t cmd = '0;
  logic cfg_valid = 1'b0;
  logic [31:0] cfg_data = '0;
  logic busy;
  logic done;
  logic cfg_ready;
  ffea_pkg::rsp_t rsp;

  first_fit_extent_allocator_top #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  bit ext_valid [ENTRIES] = '{default: 1'b0};
  logic [31:0] ext_start [ENTRIES] = '{default: '0};
  logic [31:0] ext_bytes [ENTRIES] = '{default: '0};
  logic [31:0] area_sectors = '0;

  ffea_pkg::rsp_t entry_reports_due[$];
  int errors = 0;
  bit start_on = 1'b0;
  int burst_left = 0;
  bit steady = 1'b0;

  always #4 clk = ~clk;

  function automatic logic [63:0] sectors_needed(input logic [31:0] bytes);
    return {41'd0, bytes[31:9]} + 64'(|bytes[8:0]);
  endfunction

  function automatic bit first_fit(input logic [63:0] need, output logic [31:0] where);
    logic [63:0] area;
    logic [63:0] cand;
    logic [63:0] lo;
    logic [63:0] hi;
    bit hit;
    int pass;
    int k;
    where = '0;
    area = {32'd0, area_sectors};
    cand = '0;
    if (need > area) return 1'b0;
    for (pass = 0; pass <= ENTRIES; pass++) begin
      if (cand + need > area) return 1'b0;
      hit = 1'b0;
      for (k = 0; k < ENTRIES && !hit; k++) begin
        if (ext_valid[k]) begin
          lo = {32'd0, ext_start[k]};
          hi = lo + sectors_needed(ext_bytes[k]);
          if (cand < hi && cand + need > lo) begin
            cand = hi;
            hit = 1'b1;
          end
        end
      end
      if (!hit) begin
        where = cand[31:0];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic ffea_pkg::rsp_t apply_command(input ffea_pkg::cmd_t c);
    ffea_pkg::rsp_t r;
    logic [31:0] cur_start;
    logic [31:0] cur_bytes;
    logic [31:0] new_start;
    logic [63:0] need;
    bit ok;
    int e;
    e = c.entry_index;
    r = '0;
    r.status = ffea_pkg::STATUS_OK;
    if (c.mode == ffea_pkg::MODE_WRITE) begin
      cur_start = ext_valid[e] ? ext_start[e] : '0;
      cur_bytes = ext_valid[e] ? ext_bytes[e] : '0;
      need = sectors_needed(c.size_bytes);
      new_start = cur_start;
      ok = 1'b1;
      if (need > sectors_needed(cur_bytes) || cur_start == '0) ok = first_fit(need, new_start);
      if (ok) begin
        ext_valid[e] = 1'b1;
        ext_start[e] = new_start;
        ext_bytes[e] = c.size_bytes;
      end else begin
        r.status = ffea_pkg::STATUS_NO_SPACE;
      end
    end else if (c.mode == ffea_pkg::MODE_FREE) begin
      ext_valid[e] = 1'b0;
      ext_start[e] = '0;
      ext_bytes[e] = '0;
    end
    if (ext_valid[e]) begin
      r.first_sector = ext_start[e];
      r.entry_size = ext_bytes[e];
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
  endtask

  always @(posedge clk) begin : monitor
    ffea_pkg::rsp_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) area_sectors = cfg_data;
      if (done) begin
        if (entry_reports_due.size() == 0) begin
          errors++;
          $display("%0t: result with no item pending, expected none, actual status %0d start %0d size %0d",
                   $time, rsp.status, rsp.first_sector, rsp.entry_size);
        end else begin
          want = entry_reports_due.pop_front();
          if (rsp.status !== want.status) flag_mismatch("status", want.status, rsp.status);
          if (rsp.first_sector !== want.first_sector)
            flag_mismatch("first_sector", want.first_sector, rsp.first_sector);
          if (rsp.entry_size !== want.entry_size)
            flag_mismatch("entry_size", want.entry_size, rsp.entry_size);
        end
      end
      if (start && !busy) entry_reports_due.push_back(apply_command(cmd));
    end
  end

  task automatic lower_start();
    if (start_on) begin
      start <= 1'b0;
      start_on = 1'b0;
    end
  endtask

  task automatic send_item(input logic [1:0] mode, input int idx, input logic [31:0] size);
    int gap;
    cmd <= '{mode, 6'(idx), size};
    start <= 1'b1;
    start_on = 1'b1;
    do @(posedge clk); while (busy);
    if (steady || burst_left > 0) begin
      if (burst_left > 0) burst_left--;
    end else begin
      case ($urandom_range(0, 9))
        0, 1: gap = 0;
        9: gap = $urandom_range(7, 90);
        default: gap = $urandom_range(1, 6);
      endcase
      burst_left = $urandom_range(0, 12);
      if (gap > 0) begin
        lower_start();
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    lower_start();
    @(posedge clk);
    while (entry_reports_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_area(input logic [31:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] random_size();
    logic [31:0] sz;
    int k;
    k = $urandom_range(0, 16);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: sz = $urandom_range(0, 4096);
      4, 5: begin
        sz = 32'(k) * 512;
        case ($urandom_range(0, 2))
          0: sz = sz + 1;
          1: if (k > 0) sz = sz - 1;
          default: ;
        endcase
      end
      6, 7: sz = $urandom;
      default: sz = $urandom_range(0, 1 << 20);
    endcase
    return sz;
  endfunction

  task automatic test_empty_area();
    send_item(ffea_pkg::MODE_READ, 0, 32'hFFFF_FFFF);
    send_item(MODE_ALT_READ, 63, 32'd0);
    send_item(ffea_pkg::MODE_WRITE, 0, 32'd0);
    send_item(ffea_pkg::MODE_WRITE, 1, 32'd1);
    send_item(ffea_pkg::MODE_READ, 1, 32'd0);
    send_item(ffea_pkg::MODE_FREE, 0, 32'd0);
    send_item(ffea_pkg::MODE_FREE, 0, 32'd0);
  endtask

  task automatic test_tight_area();
    write_area(32'd3);
    send_item(ffea_pkg::MODE_WRITE, 10, 32'd1024);
    send_item(ffea_pkg::MODE_WRITE, 11, 32'd512);
    send_item(ffea_pkg::MODE_WRITE, 12, 32'd1);
    send_item(ffea_pkg::MODE_WRITE, 10, 32'd1536);
    send_item(ffea_pkg::MODE_FREE, 11, 32'd0);
    send_item(ffea_pkg::MODE_WRITE, 12, 32'd100);
    send_item(ffea_pkg::MODE_WRITE, 10, 32'd0);
  endtask

  task automatic test_wide_area();
    write_area(32'hFFFF_FFFF);
    send_item(ffea_pkg::MODE_WRITE, 63, 32'hFFFF_FFFF);
    send_item(ffea_pkg::MODE_WRITE, 1, 32'd512);
    send_item(ffea_pkg::MODE_WRITE, 2, 32'd513);
    send_item(ffea_pkg::MODE_WRITE, 3, 32'd511);
    send_item(ffea_pkg::MODE_WRITE, 2, 32'd1024);
    send_item(ffea_pkg::MODE_WRITE, 1, 32'd1);
    send_item(ffea_pkg::MODE_WRITE, 1, 32'd2048);
    send_item(ffea_pkg::MODE_READ, 63, 32'd0);
    send_item(ffea_pkg::MODE_FREE, 63, 32'd0);
    send_item(ffea_pkg::MODE_WRITE, 5, 32'd1);
    send_item(ffea_pkg::MODE_WRITE, 0, 32'd0);
  endtask

  // Some items follow the life of an entry: place, resize, read back; the rest are single writes, reads and frees.
  task automatic test_random_traffic(input logic [31:0] area, input int count, input int span);
    int n;
    int e;
    int r;
    write_area(area);
    n = 0;
    while (n < count) begin
      e = $urandom_range(0, span - 1);
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_item(ffea_pkg::MODE_WRITE, e, $urandom_range(0, 2048));
        send_item(ffea_pkg::MODE_WRITE, e, random_size());
        send_item(ffea_pkg::MODE_READ, e, $urandom);
        n += 3;
      end else if (r < 55) begin
        send_item(ffea_pkg::MODE_WRITE, e, random_size());
        n++;
      end else if (r < 70) begin
        send_item(ffea_pkg::MODE_READ, e, $urandom);
        n++;
      end else if (r < 86) begin
        send_item(ffea_pkg::MODE_FREE, e, $urandom);
        n++;
      end else if (r < 93) begin
        send_item(MODE_ALT_READ, e, $urandom);
        n++;
      end else begin
        send_item(ffea_pkg::MODE_FREE, e, 32'd0);
        send_item(ffea_pkg::MODE_WRITE, e, random_size());
        n += 2;
      end
      if ($urandom_range(0, 119) == 0) drain();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_area();
    test_tight_area();
    test_wide_area();
    test_random_traffic(32'd64, 300, 16);
    steady = 1'b1;
    test_random_traffic(32'd1000, 350, 32);
    steady = 1'b0;
    test_random_traffic(32'hFFFF_FFFF, 300, 64);
    test_random_traffic(32'd24, 250, 8);
    test_random_traffic($urandom, 300, 64);
    test_random_traffic(32'd1, 200, 64);
    test_random_traffic(32'd0, 150, 8);
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && entry_reports_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
